// ===== hdl/mbrc_pkg.sv =====
// Shared constants, codes and types for the Modbus RTU response checker.
`timescale 1ns / 1ps

package mbrc_pkg;

    localparam int MAX_REGS = 32;
    localparam int IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CNT_W    = $clog2(MAX_REGS + 1);
    localparam int LIMIT_RD = (MAX_REGS < 125) ? MAX_REGS : 125;
    localparam int LIMIT_WR = (MAX_REGS < 123) ? MAX_REGS : 123;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_PARAM   = 3'd1;
    localparam logic [2:0] STAT_TIMEOUT = 3'd2;
    localparam logic [2:0] STAT_CRC     = 3'd3;
    localparam logic [2:0] STAT_EXCEPT  = 3'd4;
    localparam logic [2:0] STAT_FRAME   = 3'd5;

    localparam logic [2:0] REG_SLAVE_ADDR = 3'd0;
    localparam logic [2:0] REG_FUNC_CODE  = 3'd1;
    localparam logic [2:0] REG_COUNT      = 3'd2;
    localparam logic [2:0] REG_ACK_MODE   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT    = 3'd4;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0]  ACK_LEN        = 8'd8;
    localparam logic [7:0]  EXC_LEN        = 8'd5;
    localparam logic [7:0]  FRAME_OVERHEAD = 8'd5;

    typedef struct packed {
        logic       init;
        logic       start;
        logic [7:0] data;
    } t_crc_ctrl;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] crc;
    } t_crc_stat;

endpackage

// ===== hdl/mbrc_crc_unit.sv =====
// Bit-serial CRC-16 engine, one shift/xor step per cycle.
`timescale 1ns / 1ps

module mbrc_crc_unit
    import mbrc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_crc_ctrl i_ctrl,
    output t_crc_stat o_stat
);

    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;

    always_comb begin
        n_crc  = r_crc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_ctrl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctrl.start) begin
            n_crc  = r_crc ^ {8'h00, i_ctrl.data};
            n_cnt  = 3'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_crc = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= 3'd0;
            r_busy <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == 3'd7);
    assign o_stat.crc  = r_crc;

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("crc start while busy");

    a_init_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.init && i_ctrl.start))
        else $error("crc init and start together");

    a_eight_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 3'd7) |=> !r_busy)
        else $error("crc ran past eight steps");

endmodule

// ===== hdl/modbus_rtu_response_checker.sv =====
// Top level: Modbus RTU master response checker with APB register port.
// Start and tick transactions that raise a result hold it in the output register until it is handed off.
// A byte transaction after the second goes through accept, bit-serial CRC and check.
// The first two bytes of a frame skip the CRC and go from accept straight to check.
// An ok read emits its results one at a time (register file read, load, hand-off); a stall holds it.
// Reset (synchronous, active low) disarms, clears counters and loads the register defaults.
`timescale 1ns / 1ps

module modbus_rtu_response_checker
    import mbrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [15:0]       o_reg_value,
    output logic [5:0]        o_reg_index,
    output logic              o_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CRC   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_LD    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // configuration
    logic [7:0]  r_cfg_addr, r_cfg_fc;
    logic [6:0]  r_cfg_count;
    logic        r_cfg_ack;
    logic [15:0] r_cfg_timeout;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // transaction state
    logic [2:0]  r_state, n_state;
    logic        r_armed, n_armed;
    logic [7:0]  r_bytes, n_bytes;
    logic [7:0]  r_exp, n_exp;
    logic [15:0] r_last_two, n_last_two;
    logic [23:0] r_header, n_header;
    logic [15:0] r_ticks, n_ticks;

    // result path
    logic [2:0]       r_out_status, n_out_status;
    logic [15:0]      r_out_value, n_out_value;
    logic [5:0]       r_out_index, n_out_index;
    logic             r_out_last, n_out_last;
    logic [IDX_W-1:0] r_emit_idx, n_emit_idx;
    logic [CNT_W-1:0] r_emit_n, n_emit_n;

    // register store, byte-wide halves
    logic [7:0]       r_mem_hi [MAX_REGS];
    logic [7:0]       r_mem_lo [MAX_REGS];
    logic [7:0]       r_rd_hi, r_rd_lo;
    logic             mem_we_hi, mem_we_lo;
    logic [IDX_W-1:0] mem_waddr;

    t_crc_ctrl crc_ctrl;
    t_crc_stat crc_stat;

    logic        in_acc;
    logic [7:0]  bytes_inc, data_off, data_len, start_len;
    logic [8:0]  pos_plus2;
    logic [6:0]  reg_n, count_limit;
    logic        store_hit, start_bad, frame_bad_ack, frame_bad_rd;
    logic [15:0] crc_rx;

    // APB
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_addr    <= 8'd1;
            r_cfg_fc      <= 8'd3;
            r_cfg_count   <= 7'd1;
            r_cfg_ack     <= 1'b0;
            r_cfg_timeout <= 16'd1000;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SLAVE_ADDR: r_cfg_addr    <= pwdata[7:0];
                REG_FUNC_CODE:  r_cfg_fc      <= pwdata[7:0];
                REG_COUNT:      r_cfg_count   <= pwdata[6:0];
                REG_ACK_MODE:   r_cfg_ack     <= pwdata[0];
                REG_TIMEOUT:    r_cfg_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SLAVE_ADDR: prdata = {24'd0, r_cfg_addr};
            REG_FUNC_CODE:  prdata = {24'd0, r_cfg_fc};
            REG_COUNT:      prdata = {25'd0, r_cfg_count};
            REG_ACK_MODE:   prdata = {31'd0, r_cfg_ack};
            REG_TIMEOUT:    prdata = {16'd0, r_cfg_timeout};
            default:        prdata = '0;
        endcase
    end

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_out_status;
    assign o_reg_value = r_out_value;
    assign o_reg_index = r_out_index;
    assign o_last      = r_out_last;

    // datapath helpers
    assign count_limit = r_cfg_ack ? 7'(LIMIT_WR) : 7'(LIMIT_RD);
    assign start_bad   = (r_cfg_addr == 8'd0) || (r_cfg_count == 7'd0)
                         || (r_cfg_count > count_limit);
    assign start_len   = r_cfg_ack ? ACK_LEN : ({r_cfg_count, 1'b0} + FRAME_OVERHEAD);

    assign bytes_inc = r_bytes + 8'd1;
    assign pos_plus2 = {1'b0, r_bytes} + 9'd2;
    assign data_off  = r_bytes - 8'd3;
    assign store_hit = r_exp[0] && (r_exp != EXC_LEN) && (r_bytes >= 8'd3)
                       && (pos_plus2 < {1'b0, r_exp})
                       && ({1'b0, data_off[7:1]} < 8'(MAX_REGS));
    assign mem_waddr = data_off[IDX_W:1];

    assign data_len      = r_exp - FRAME_OVERHEAD;
    assign reg_n         = data_len[7:1];
    assign crc_rx        = {r_last_two[7:0], r_last_two[15:8]};
    assign frame_bad_ack = (r_header[7:0] != r_cfg_addr) || (r_header[15:8] != FC_WRITE_MULTI);
    assign frame_bad_rd  = (r_header[7:0] != r_cfg_addr) || (r_header[15:8] != r_cfg_fc)
                           || (r_header[23:16] != {reg_n, 1'b0}) || (reg_n == 7'd0)
                           || (reg_n > 7'(MAX_REGS));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_armed      = r_armed;
        n_bytes      = r_bytes;
        n_exp        = r_exp;
        n_last_two   = r_last_two;
        n_header     = r_header;
        n_ticks      = r_ticks;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_index  = r_out_index;
        n_out_last   = r_out_last;
        n_emit_idx   = r_emit_idx;
        n_emit_n     = r_emit_n;
        crc_ctrl     = '0;
        mem_we_hi    = 1'b0;
        mem_we_lo    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_START: begin
                            if (start_bad) begin
                                n_armed      = 1'b0;
                                n_out_status = STAT_PARAM;
                                n_out_value  = 16'd0;
                                n_out_index  = 6'd0;
                                n_out_last   = 1'b1;
                                n_state      = S_OUT;
                            end else begin
                                n_armed       = 1'b1;
                                n_bytes       = 8'd0;
                                n_exp         = start_len;
                                n_last_two    = 16'd0;
                                n_header      = 24'd0;
                                n_ticks       = 16'd0;
                                crc_ctrl.init = 1'b1;
                            end
                        end
                        CMD_BYTE: begin
                            if (r_armed) begin
                                if (r_bytes >= 8'd2) begin
                                    crc_ctrl.start = 1'b1;
                                    crc_ctrl.data  = r_last_two[15:8];
                                    n_state        = S_CRC;
                                end else begin
                                    n_state = S_CHECK;
                                end
                                n_last_two = {r_last_two[7:0], i_rx_byte};
                                if (r_bytes == 8'd0) begin
                                    n_header[7:0] = r_header[7:0] | i_rx_byte;
                                end else if (r_bytes == 8'd1) begin
                                    n_header[15:8] = r_header[15:8] | i_rx_byte;
                                end else if (r_bytes == 8'd2) begin
                                    n_header[23:16] = r_header[23:16] | i_rx_byte;
                                end
                                if (store_hit) begin
                                    mem_we_hi = !data_off[0];
                                    mem_we_lo = data_off[0];
                                end
                                n_bytes = bytes_inc;
                                // exception frame: function byte with bit 7 set
                                if (bytes_inc == 8'd2 && i_rx_byte[7]) begin
                                    n_exp = EXC_LEN;
                                end
                            end
                        end
                        CMD_TICK: begin
                            if (r_armed) begin
                                if (r_ticks >= r_cfg_timeout) begin
                                    n_armed      = 1'b0;
                                    n_out_status = STAT_TIMEOUT;
                                    n_out_value  = 16'd0;
                                    n_out_index  = 6'd0;
                                    n_out_last   = 1'b1;
                                    n_state      = S_OUT;
                                end else begin
                                    n_ticks = r_ticks + 16'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CRC: begin
                if (crc_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_bytes >= r_exp) begin
                    n_armed     = 1'b0;
                    n_out_value = 16'd0;
                    n_out_index = 6'd0;
                    n_out_last  = 1'b1;
                    n_state     = S_OUT;
                    if (crc_rx != crc_stat.crc) begin
                        n_out_status = STAT_CRC;
                    end else if (r_header[15]) begin
                        n_out_status = STAT_EXCEPT;
                    end else if (r_exp == ACK_LEN) begin
                        n_out_status = frame_bad_ack ? STAT_FRAME : STAT_OK;
                    end else if (frame_bad_rd) begin
                        n_out_status = STAT_FRAME;
                    end else begin
                        n_emit_idx = '0;
                        n_emit_n   = CNT_W'(reg_n);
                        n_state    = S_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_out_status = STAT_OK;
                n_out_value  = {r_rd_hi, r_rd_lo};
                n_out_index  = 6'(r_emit_idx);
                n_out_last   = ((CNT_W'(r_emit_idx) + CNT_W'(1)) == r_emit_n);
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + IDX_W'(1);
                        n_state    = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_armed    <= 1'b0;
            r_bytes    <= 8'd0;
            r_exp      <= 8'd0;
            r_last_two <= 16'd0;
            r_header   <= 24'd0;
            r_ticks    <= 16'd0;
        end else begin
            r_state    <= n_state;
            r_armed    <= n_armed;
            r_bytes    <= n_bytes;
            r_exp      <= n_exp;
            r_last_two <= n_last_two;
            r_header   <= n_header;
            r_ticks    <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_index  <= n_out_index;
        r_out_last   <= n_out_last;
        r_emit_idx   <= n_emit_idx;
        r_emit_n     <= n_emit_n;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we_hi) begin
            r_mem_hi[mem_waddr] <= i_rx_byte;
        end
        if (mem_we_lo) begin
            r_mem_lo[mem_waddr] <= i_rx_byte;
        end
        r_rd_hi <= r_mem_hi[r_emit_idx];
        r_rd_lo <= r_mem_lo[r_emit_idx];
    end

    mbrc_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_stat  (crc_stat)
    );

    a_crc_state_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC) |-> crc_stat.busy)
        else $error("CRC wait state without a running CRC");

    a_last_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |-> !r_armed)
        else $error("final result while still armed");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed && r_state == S_IDLE) |-> (r_bytes < r_exp))
        else $error("armed with a complete frame");

endmodule
